### sv/mtag_pkg.sv
// Package for the mode 7 texel address generator: shared types, register
// indexes, the quarter-wave sine table and the fixed-point helper functions.
// Depends on nothing; the other RTL files and the bench import it.
package mtag_pkg;

  localparam int TDATA_W     = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Row distance divider: numerator is depth_scale with 16 fraction bits.
  localparam int QUO_W  = 36;
  // Magnitude of (trig difference * column) and its product with distance.
  localparam int MAGC_W = 26;
  localparam int PROD_W = MAGC_W + QUO_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE        = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_VIEW_ANGLE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_X    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_Y    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_HALF_HEIGHT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEPTH_SCALE = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_HORIZON     = 3'd7;

  typedef struct packed {
    logic               perspective_mode;
    logic [9:0]         view_angle;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic [9:0]         half_width;
    logic [9:0]         half_height;
    logic [19:0]        depth_scale;
    logic [9:0]         horizon;
  } mtag_cfg_t;

  // One classified pixel as it waits between the front and the back.
  typedef struct packed {
    logic               mode;
    logic [9:0]         col;
    logic [10:0]        div;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
  } mtag_item_t;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] TAYLOR_DEN [1:10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                  64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef logic [256:0][14:0] qsin_t;

  // round(16384*sin(k*pi/512)) by a Q30 Taylor series, evaluated at elaboration.
  function automatic logic [14:0] quarter_sin(input logic [8:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    x  = (64'(k) * PI_Q30) / 64'd512;
    x2 = (x * x) >> 30;
    t  = x;
    s  = signed'(x);
    for (int n = 1; n <= 10; n++) begin
      t = ((t * x2) >> 30) / TAYLOR_DEN[n];
      if (n[0]) s = s - signed'(t);
      else      s = s + signed'(t);
    end
    if (s < 0) s = '0;
    return 15'((unsigned'(s) + 64'd32768) >> 16);
  endfunction

  function automatic qsin_t build_qsin();
    qsin_t tbl;
    for (int k = 0; k <= 256; k++) begin
      tbl[k] = quarter_sin(9'(k));
    end
    return tbl;
  endfunction

  localparam qsin_t QSIN = build_qsin();

  function automatic logic signed [15:0] sin_q14(input logic [9:0] idx);
    logic [8:0]         q;
    logic [8:0]         qm;
    logic signed [15:0] m;
    q  = idx[8:0];
    qm = (q <= 9'd256) ? q : 9'(10'd512 - {1'b0, q});
    m  = signed'({1'b0, QSIN[qm]});
    return idx[9] ? -m : m;
  endfunction

  function automatic logic signed [15:0] cos_q14(input logic [9:0] idx);
    return sin_q14(idx + 10'd256);
  endfunction

  // Low ten bits of v / 2^frac truncated toward zero.
  function automatic logic [9:0] trunc_low(input logic signed [63:0] v, input int frac);
    logic signed [63:0] sh;
    logic [63:0]        fmask;
    logic               nz;
    sh    = v >>> frac;
    fmask = (64'd1 << frac) - 64'd1;
    nz    = |(v & fmask);
    return sh[9:0] + {9'd0, v[63] & nz};
  endfunction

endpackage

### sv/mode7_texel_address_gen.sv
// Top level of the mode 7 texel address generator: configuration registers,
// front end, queue and back end. Uses mtag_pkg, mtag_front, mtag_queue, mtag_back.
//
// One pixel request enters per clock and one texel address leaves per clock
// for as long as the output side takes them. A request is registered in the
// front end, waits in the queue, and then passes through the back end: the
// sine table and the top-down rotation, the row distance divider (one
// quotient bit per stage), the products with that distance, the division by
// SAMPLE_WIDTH (a multiplication by its reciprocal in 32-bit pieces, the sum
// of the cross products, and the recombination), the final add and the
// output register. The back end holds still while a result waits on
// out_tready; the four-entry queue keeps the front end taking requests
// meanwhile. Both view modes pass through the same stages, so results always
// leave in request order.
// Configuration writes take effect at once and should be made only while no
// request is in flight.
module mode7_texel_address_gen #(
  parameter int TEXTURE_SIZE = 1024,
  parameter int SAMPLE_WIDTH = 200,
  parameter int FOV_DIVIDER  = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mtag_pkg::TDATA_W-1:0]       in_tdata,   // screen_col [9:0], screen_row [19:10]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mtag_pkg::TDATA_W-1:0]       out_tdata,  // texel_x [9:0], texel_y [19:10]
  input  logic                               cfg_we,
  input  logic [mtag_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [mtag_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mtag_pkg::*;

  mtag_cfg_t  cfg_r;
  mtag_item_t front_item;
  mtag_item_t head_item;
  logic       push;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic [9:0] texel_x;
  logic [9:0] texel_y;

  // Register writes; reset values match the power-on view.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.perspective_mode <= 1'b0;
      cfg_r.view_angle       <= '0;
      cfg_r.centre_x         <= '0;
      cfg_r.centre_y         <= '0;
      cfg_r.half_width       <= 10'd300;
      cfg_r.half_height      <= 10'd300;
      cfg_r.depth_scale      <= 20'd10000;
      cfg_r.horizon          <= 10'd5;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:        cfg_r.perspective_mode <= cfg_wdata[0];
        CFG_VIEW_ANGLE:  cfg_r.view_angle       <= cfg_wdata[9:0];
        CFG_CENTRE_X:    cfg_r.centre_x         <= signed'(cfg_wdata[15:0]);
        CFG_CENTRE_Y:    cfg_r.centre_y         <= signed'(cfg_wdata[15:0]);
        CFG_HALF_WIDTH:  cfg_r.half_width       <= cfg_wdata[9:0];
        CFG_HALF_HEIGHT: cfg_r.half_height      <= cfg_wdata[9:0];
        CFG_DEPTH_SCALE: cfg_r.depth_scale      <= cfg_wdata[19:0];
        CFG_HORIZON:     cfg_r.horizon          <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  mtag_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_col   (in_tdata[9:0]),
    .in_row   (in_tdata[19:10]),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .item     (front_item)
  );

  mtag_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  mtag_back #(
    .TEXTURE_SIZE (TEXTURE_SIZE),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FOV_DIVIDER  (FOV_DIVIDER)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .texel_x   (texel_x),
    .texel_y   (texel_y)
  );

  assign out_tdata = {(TDATA_W - 20)'(0), texel_y, texel_x};

endmodule

### sv/mtag_front.sv
// Front end of the texel address generator: takes pixel requests and
// classifies them (mode, row divisor, centre offsets). Uses mtag_pkg.
module mtag_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [9:0]            in_col,
  input  logic [9:0]            in_row,
  input  mtag_pkg::mtag_cfg_t   cfg,
  input  logic                  q_full,
  output logic                  push,
  output mtag_pkg::mtag_item_t  item
);
  import mtag_pkg::*;

  logic       front_v_r;
  mtag_item_t item_r;
  mtag_item_t item_nxt;
  logic [10:0] div_raw;

  assign push     = front_v_r && !q_full;
  assign in_ready = !front_v_r || !q_full;
  assign item     = item_r;

  always_comb begin
    div_raw       = {1'b0, in_row} + {1'b0, cfg.horizon};
    item_nxt.mode = cfg.perspective_mode;
    item_nxt.col  = in_col;
    // A zero divisor only arises with horizon written as zero on row zero.
    item_nxt.div  = (div_raw == 11'd0) ? 11'd1 : div_raw;
    item_nxt.dx   = signed'({1'b0, in_col} - {1'b0, cfg.half_width});
    item_nxt.dy   = signed'({1'b0, in_row} - {1'b0, cfg.half_height});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      front_v_r <= 1'b1;
    end else if (push) begin
      front_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

### sv/mtag_queue.sv
// Short queue between the front and back of the texel address generator.
// Holds classified pixels in registers. Uses mtag_pkg.
module mtag_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mtag_pkg::mtag_item_t  push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output mtag_pkg::mtag_item_t  head
);
  import mtag_pkg::*;

  mtag_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

### sv/mtag_back.sv
// Back end of the texel address generator: trig lookup, row distance divider,
// multiply stages, division by the sample width and output register. Uses mtag_pkg.
module mtag_back #(
  parameter int TEXTURE_SIZE = 1024,
  parameter int SAMPLE_WIDTH = 200,
  parameter int FOV_DIVIDER  = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mtag_pkg::mtag_cfg_t   cfg,
  input  logic                  q_valid,
  input  mtag_pkg::mtag_item_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [9:0]            texel_x,
  output logic [9:0]            texel_y
);
  import mtag_pkg::*;

  localparam logic [9:0] FOV_HALF = 10'((512 + FOV_DIVIDER / 2) / FOV_DIVIDER);
  localparam logic [9:0] OUT_MASK = 10'((TEXTURE_SIZE - 1) & 1023);
  // Exact floor division by SAMPLE_WIDTH as a multiplication by a rounded-up
  // reciprocal; the shift leaves room for every numerator below 2^PROD_W.
  localparam int          RSHIFT  = PROD_W + $clog2(SAMPLE_WIDTH);
  localparam logic [127:0] RECIP_W = ((128'd1 << RSHIFT) + 128'(SAMPLE_WIDTH - 1))
                                     / 128'(SAMPLE_WIDTH);
  localparam logic [62:0] RECIP    = 63'(RECIP_W);

  typedef struct packed {
    logic               mode;
    logic [9:0]         col;
    logic [10:0]        div;
    logic signed [10:0] dx, dy;
    logic signed [15:0] cs, ss, ce, se, ct, st;
  } p0_t;

  typedef struct packed {
    logic               mode;
    logic [9:0]         col;
    logic [10:0]        div;
    logic signed [31:0] rx, ry;
    logic signed [15:0] cs, ss;
    logic               sgx, sgy;
    logic [15:0]        magx, magy;
  } p1_t;

  typedef struct packed {
    logic               mode;
    logic [19:0]        td;
    logic [10:0]        div;
    logic signed [15:0] cs, ss;
    logic               sgx, sgy;
    logic [MAGC_W-1:0]  mcx, mcy;
    logic [10:0]        rem;
    logic [QUO_W-1:0]   quo;
  } dst_t;

  typedef struct packed {
    logic               mode;
    logic [19:0]        td;
    logic               sgx, sgy;
    logic signed [52:0] pxt, pyt;
    logic [43:0]        xl, xh, yl, yh;
  } m0_t;

  typedef struct packed {
    logic               mode;
    logic [19:0]        td;
    logic               sgx, sgy;
    logic signed [63:0] sx, sy;
    logic [PROD_W-1:0]  nx, ny;
  } m1_t;

  typedef struct packed {
    logic               mode;
    logic [19:0]        td;
    logic               sgx, sgy;
    logic signed [63:0] sx, sy;
    logic [63:0]        x00, x01, x10, x11, y00, y01, y10, y11;
  } c0_t;

  typedef struct packed {
    logic               mode;
    logic [19:0]        td;
    logic               sgx, sgy;
    logic signed [63:0] sx, sy;
    logic [63:0]        x00, x11, y00, y11;
    logic [64:0]        xmid, ymid;
  } c1_t;

  typedef struct packed {
    logic               mode;
    logic [19:0]        td;
    logic               sgx, sgy;
    logic signed [63:0] sx, sy;
    logic [PROD_W-1:0]  qx, qy;
  } c2_t;

  typedef struct packed {
    logic               mode;
    logic [19:0]        td;
    logic signed [63:0] px, py;
  } f0_t;

  logic adv;
  logic p0_v_r, p1_v_r, m0_v_r, m1_v_r, c0_v_r, c1_v_r, c2_v_r, f0_v_r, out_v_r;
  logic [QUO_W-1:0]  dv_r;
  p0_t  p0_r, p0_nxt;
  p1_t  p1_r, p1_nxt;
  dst_t d_r [QUO_W];
  dst_t d_nxt [QUO_W];
  dst_t d_first;
  m0_t  m0_r, m0_nxt;
  m1_t  m1_r, m1_nxt;
  c0_t  c0_r, c0_nxt;
  c1_t  c1_r, c1_nxt;
  c2_t  c2_r, c2_nxt;
  f0_t  f0_r, f0_nxt;
  logic [9:0] tx_r, ty_r, tx_nxt, ty_nxt;
  logic [QUO_W-1:0] num;

  function automatic dst_t div_step(input dst_t p, input logic nbit);
    dst_t        n;
    logic [11:0] r;
    logic        take;
    n    = p;
    r    = {p.rem, nbit};
    take = (r >= {1'b0, p.div});
    n.rem = take ? 11'(r - {1'b0, p.div}) : r[10:0];
    n.quo = {p.quo[QUO_W-2:0], take};
    return n;
  endfunction

  // Recombines the 32-bit partial products and keeps the quotient bits.
  function automatic logic [PROD_W-1:0] recip_fold(input logic [63:0] p00,
                                                   input logic [63:0] p11,
                                                   input logic [64:0] mid);
    logic [127:0] full;
    full = {p11, p00} + {31'd0, mid, 32'd0};
    return PROD_W'(full >> RSHIFT);
  endfunction

  assign adv       = !out_v_r || out_ready;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_v_r;
  assign texel_x   = tx_r;
  assign texel_y   = ty_r;
  assign num       = {cfg.depth_scale, 16'd0};

  // Stage P0: trig lookups for both modes.
  always_comb begin
    logic [9:0] as_a, ae_a, td_a;
    as_a = FOV_HALF - cfg.view_angle;
    ae_a = 10'd0 - cfg.view_angle - FOV_HALF;
    td_a = cfg.view_angle + 10'd256;
    p0_nxt.mode = q_item.mode;
    p0_nxt.col  = q_item.col;
    p0_nxt.div  = q_item.div;
    p0_nxt.dx   = q_item.dx;
    p0_nxt.dy   = q_item.dy;
    p0_nxt.cs   = cos_q14(as_a);
    p0_nxt.ss   = sin_q14(as_a);
    p0_nxt.ce   = cos_q14(ae_a);
    p0_nxt.se   = sin_q14(ae_a);
    p0_nxt.ct   = cos_q14(td_a);
    p0_nxt.st   = sin_q14(td_a);
  end

  // Stage P1: top-down rotation and perspective trig differences.
  always_comb begin
    logic signed [16:0] dcx, dsy;
    dcx = 17'(p0_r.ce) - 17'(p0_r.cs);
    dsy = 17'(p0_r.ss) - 17'(p0_r.se);
    p1_nxt.mode = p0_r.mode;
    p1_nxt.col  = p0_r.col;
    p1_nxt.div  = p0_r.div;
    p1_nxt.rx   = 32'(p0_r.dx) * 32'(p0_r.ct) - 32'(p0_r.dy) * 32'(p0_r.st)
                + (32'(cfg.centre_x) <<< 14);
    p1_nxt.ry   = 32'(p0_r.dx) * 32'(p0_r.st) + 32'(p0_r.dy) * 32'(p0_r.ct)
                + (32'(cfg.centre_y) <<< 14);
    p1_nxt.cs   = p0_r.cs;
    p1_nxt.ss   = p0_r.ss;
    p1_nxt.sgx  = dcx[16];
    p1_nxt.sgy  = dsy[16];
    p1_nxt.magx = dcx[16] ? 16'(-dcx) : dcx[15:0];
    p1_nxt.magy = dsy[16] ? 16'(-dsy) : dsy[15:0];
  end

  // Row distance divider, one quotient bit per stage.
  always_comb begin
    d_first.mode = p1_r.mode;
    d_first.td   = {trunc_low(64'(p1_r.ry), 14), trunc_low(64'(p1_r.rx), 14)};
    d_first.div  = p1_r.div;
    d_first.cs   = p1_r.cs;
    d_first.ss   = p1_r.ss;
    d_first.sgx  = p1_r.sgx;
    d_first.sgy  = p1_r.sgy;
    d_first.mcx  = MAGC_W'(p1_r.magx) * MAGC_W'(p1_r.col);
    d_first.mcy  = MAGC_W'(p1_r.magy) * MAGC_W'(p1_r.col);
    d_first.rem  = '0;
    d_first.quo  = '0;
    for (int i = 0; i < QUO_W; i++) begin
      d_nxt[i] = div_step((i == 0) ? d_first : d_r[(i == 0) ? 0 : i - 1], num[QUO_W-1-i]);
    end
  end

  // Stage M0: products with the row distance, the wide ones in two halves.
  always_comb begin
    dst_t dl;
    dl = d_r[QUO_W-1];
    m0_nxt.mode = dl.mode;
    m0_nxt.td   = dl.td;
    m0_nxt.sgx  = dl.sgx;
    m0_nxt.sgy  = dl.sgy;
    m0_nxt.pxt  = 53'(dl.cs) * signed'({17'd0, dl.quo});
    m0_nxt.pyt  = 53'(dl.ss) * signed'({17'd0, dl.quo});
    m0_nxt.xl   = 44'(dl.mcx) * 44'(dl.quo[17:0]);
    m0_nxt.xh   = 44'(dl.mcx) * 44'(dl.quo[QUO_W-1:18]);
    m0_nxt.yl   = 44'(dl.mcy) * 44'(dl.quo[17:0]);
    m0_nxt.yh   = 44'(dl.mcy) * 44'(dl.quo[QUO_W-1:18]);
  end

  // Stage M1: start points and recombined interpolation numerators.
  always_comb begin
    m1_nxt.mode = m0_r.mode;
    m1_nxt.td   = m0_r.td;
    m1_nxt.sgx  = m0_r.sgx;
    m1_nxt.sgy  = m0_r.sgy;
    m1_nxt.sx   = (64'(cfg.centre_x) <<< 30) + 64'(m0_r.pxt);
    m1_nxt.sy   = (64'(cfg.centre_y) <<< 30) - 64'(m0_r.pyt);
    m1_nxt.nx   = (PROD_W'(m0_r.xh) << 18) + PROD_W'(m0_r.xl);
    m1_nxt.ny   = (PROD_W'(m0_r.yh) << 18) + PROD_W'(m0_r.yl);
  end

  // Stage C0: numerator times reciprocal, as four 32 by 32 bit products.
  always_comb begin
    c0_nxt.mode = m1_r.mode;
    c0_nxt.td   = m1_r.td;
    c0_nxt.sgx  = m1_r.sgx;
    c0_nxt.sgy  = m1_r.sgy;
    c0_nxt.sx   = m1_r.sx;
    c0_nxt.sy   = m1_r.sy;
    c0_nxt.x00  = 64'(m1_r.nx[31:0]) * 64'(RECIP[31:0]);
    c0_nxt.x01  = 64'(m1_r.nx[31:0]) * 64'(RECIP[62:32]);
    c0_nxt.x10  = 64'(m1_r.nx[PROD_W-1:32]) * 64'(RECIP[31:0]);
    c0_nxt.x11  = 64'(m1_r.nx[PROD_W-1:32]) * 64'(RECIP[62:32]);
    c0_nxt.y00  = 64'(m1_r.ny[31:0]) * 64'(RECIP[31:0]);
    c0_nxt.y01  = 64'(m1_r.ny[31:0]) * 64'(RECIP[62:32]);
    c0_nxt.y10  = 64'(m1_r.ny[PROD_W-1:32]) * 64'(RECIP[31:0]);
    c0_nxt.y11  = 64'(m1_r.ny[PROD_W-1:32]) * 64'(RECIP[62:32]);
  end

  // Stage C1: sum of the cross products.
  always_comb begin
    c1_nxt.mode = c0_r.mode;
    c1_nxt.td   = c0_r.td;
    c1_nxt.sgx  = c0_r.sgx;
    c1_nxt.sgy  = c0_r.sgy;
    c1_nxt.sx   = c0_r.sx;
    c1_nxt.sy   = c0_r.sy;
    c1_nxt.x00  = c0_r.x00;
    c1_nxt.x11  = c0_r.x11;
    c1_nxt.y00  = c0_r.y00;
    c1_nxt.y11  = c0_r.y11;
    c1_nxt.xmid = 65'(c0_r.x01) + 65'(c0_r.x10);
    c1_nxt.ymid = 65'(c0_r.y01) + 65'(c0_r.y10);
  end

  // Stage C2: full product and the quotient taken from its top bits.
  always_comb begin
    c2_nxt.mode = c1_r.mode;
    c2_nxt.td   = c1_r.td;
    c2_nxt.sgx  = c1_r.sgx;
    c2_nxt.sgy  = c1_r.sgy;
    c2_nxt.sx   = c1_r.sx;
    c2_nxt.sy   = c1_r.sy;
    c2_nxt.qx   = recip_fold(c1_r.x00, c1_r.x11, c1_r.xmid);
    c2_nxt.qy   = recip_fold(c1_r.y00, c1_r.y11, c1_r.ymid);
  end

  // Stage F0: add the signed quotient to the start point.
  always_comb begin
    f0_nxt.mode = c2_r.mode;
    f0_nxt.td   = c2_r.td;
    f0_nxt.px   = c2_r.sx + (c2_r.sgx ? -signed'(64'(c2_r.qx)) : signed'(64'(c2_r.qx)));
    f0_nxt.py   = c2_r.sy + (c2_r.sgy ? -signed'(64'(c2_r.qy)) : signed'(64'(c2_r.qy)));
  end

  always_comb begin
    if (f0_r.mode) begin
      tx_nxt = trunc_low(f0_r.px, 30) & OUT_MASK;
      ty_nxt = trunc_low(f0_r.py, 30) & OUT_MASK;
    end else begin
      tx_nxt = f0_r.td[9:0] & OUT_MASK;
      ty_nxt = f0_r.td[19:10] & OUT_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r  <= 1'b0;
      p1_v_r  <= 1'b0;
      dv_r    <= '0;
      m0_v_r  <= 1'b0;
      m1_v_r  <= 1'b0;
      c0_v_r  <= 1'b0;
      c1_v_r  <= 1'b0;
      c2_v_r  <= 1'b0;
      f0_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      p0_v_r  <= q_valid;
      p1_v_r  <= p0_v_r;
      dv_r    <= {dv_r[QUO_W-2:0], p1_v_r};
      m0_v_r  <= dv_r[QUO_W-1];
      m1_v_r  <= m0_v_r;
      c0_v_r  <= m1_v_r;
      c1_v_r  <= c0_v_r;
      c2_v_r  <= c1_v_r;
      f0_v_r  <= c2_v_r;
      out_v_r <= f0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      for (int i = 0; i < QUO_W; i++) d_r[i] <= d_nxt[i];
      m0_r <= m0_nxt;
      m1_r <= m1_nxt;
      c0_r <= c0_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      f0_r <= f0_nxt;
      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
    end
  end

endmodule

### sv/mtag_checker.sv
// Port-level checks for the mode 7 texel address generator, bound to the
// top level. Depends only on the top level's ports.
module mtag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result request shown straight after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result request changed");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0)
    else $error("padding bits of the result are not zero");

endmodule

bind mode7_texel_address_gen mtag_checker u_mtag_checker (.*);

### bench/tb_mode7_texel_address_gen.sv
// Self-checking bench for mode7_texel_address_gen: drives pixel requests,
// predicts each texel address in both view modes and checks every result.
// Depends on mtag_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_mode7_texel_address_gen;
  import mtag_pkg::*;

  localparam int FOV_HALF  = 102;   // half field of view in angle units
  localparam int RUN_LIMIT = 300000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mode7_texel_address_gen i_dut (.*);

  // Pixel requests waiting to be driven, and texel addresses still owed.
  logic [19:0] pixel_q [$];
  logic [19:0] texel_q [$];
  mtag_cfg_t   view_cfg;
  int          sine_tab [0:1023];
  int          send_idle_pct;
  int          recv_idle_pct;
  int          fail_count;
  int          cycle_count;
  logic        req_taken;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Full-turn Q1.14 sine table, built from a Q30 Taylor series of the
  // first quarter and mirrored into the other three.
  function automatic int quarter_wave(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    x  = (longint'(k) * 64'd3373259426) / 64'd512;
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      t = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    return int'((longint'(s) + 32768) >>> 16);
  endfunction

  function automatic longint sine_of(int idx);
    return longint'(sine_tab[idx & 1023]);
  endfunction

  // Truncate toward zero at the given fraction bits, then wrap to the texture.
  function automatic logic [9:0] wrap_coord(longint v, int frac);
    longint r;
    if (v < 0) r = -((-v) >>> frac);
    else r = v >>> frac;
    return r[9:0];
  endfunction

  function automatic logic [19:0] texel_for(logic [9:0] col, logic [9:0] row);
    longint c, s, dx, dy, row_dist, sx, sy, ex, ey;
    longint divisor;
    int     a, a_start, a_end;
    if (!view_cfg.perspective_mode) begin
      // Top-down: rotate the offset from the view centre about the pivot.
      a  = (int'(view_cfg.view_angle) + 256) & 1023;
      c  = sine_of(a + 256);
      s  = sine_of(a);
      dx = longint'(col) - longint'(view_cfg.half_width);
      dy = longint'(row) - longint'(view_cfg.half_height);
      return {wrap_coord(dx * s + dy * c + longint'(view_cfg.centre_y) * 16384, 14),
              wrap_coord(dx * c - dy * s + longint'(view_cfg.centre_x) * 16384, 14)};
    end
    // Perspective: row distance, then interpolate across the field of view.
    divisor = longint'(row) + longint'(view_cfg.horizon);
    if (divisor == 0) divisor = 1;
    row_dist = (longint'(view_cfg.depth_scale) << 16) / divisor;
    a_start = (1024 - int'(view_cfg.view_angle) + FOV_HALF) & 1023;
    a_end   = (2048 - int'(view_cfg.view_angle) - FOV_HALF) & 1023;
    sx = longint'(view_cfg.centre_x) * (64'sd1 << 30) + sine_of(a_start + 256) * row_dist;
    sy = longint'(view_cfg.centre_y) * (64'sd1 << 30) - sine_of(a_start) * row_dist;
    ex = longint'(view_cfg.centre_x) * (64'sd1 << 30) + sine_of(a_end + 256) * row_dist;
    ey = longint'(view_cfg.centre_y) * (64'sd1 << 30) - sine_of(a_end) * row_dist;
    return {wrap_coord(sy + ((ey - sy) * longint'(col)) / 200, 30),
            wrap_coord(sx + ((ex - sx) * longint'(col)) / 200, 30)};
  endfunction

  // Request driver: presents the next pixel on the falling edge once the
  // previous one has been taken, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_taken) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= {4'd0, pixel_q.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: records taken requests with their prediction and checks results.
  always @(posedge clk) begin
    logic [19:0] want;
    req_taken   = rst_n && in_tvalid && in_tready;
    cycle_count = cycle_count + 1;
    if (req_taken) texel_q.push_back(texel_for(in_tdata[9:0], in_tdata[19:10]));
    if (rst_n && out_tvalid && out_tready) begin
      if (texel_q.size() == 0) begin
        $error("texel address with no request outstanding: %h", out_tdata[19:0]);
        fail_count++;
      end else begin
        want = texel_q.pop_front();
        if (out_tdata[9:0] !== want[9:0]) begin
          $error("texel_x expected %0d got %0d", want[9:0], out_tdata[9:0]);
          fail_count++;
        end
        if (out_tdata[19:10] !== want[19:10]) begin
          $error("texel_y expected %0d got %0d", want[19:10], out_tdata[19:10]);
          fail_count++;
        end
      end
    end
    if (cycle_count > RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_addr  = idx;
    cfg_wdata = val;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Writes every register from view_cfg, so the bench copy matches the block.
  task automatic load_view();
    write_reg(CFG_MODE, CFG_DATA_W'(view_cfg.perspective_mode));
    write_reg(CFG_VIEW_ANGLE, CFG_DATA_W'(view_cfg.view_angle));
    write_reg(CFG_CENTRE_X, CFG_DATA_W'(unsigned'(view_cfg.centre_x)));
    write_reg(CFG_CENTRE_Y, CFG_DATA_W'(unsigned'(view_cfg.centre_y)));
    write_reg(CFG_HALF_WIDTH, CFG_DATA_W'(view_cfg.half_width));
    write_reg(CFG_HALF_HEIGHT, CFG_DATA_W'(view_cfg.half_height));
    write_reg(CFG_DEPTH_SCALE, view_cfg.depth_scale);
    write_reg(CFG_HORIZON, CFG_DATA_W'(view_cfg.horizon));
  endtask

  // Waits until every request is driven and answered, then lets the back
  // end's pipeline run dry before anything else changes.
  task automatic drain();
    while (pixel_q.size() > 0 || in_tvalid || texel_q.size() > 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    int qs [0:256];
    int q;
    rst_n = 1'b0;  in_tvalid = 1'b0;  in_tdata = '0;  out_tready = 1'b0;
    cfg_we = 1'b0;  cfg_addr = '0;  cfg_wdata = '0;
    fail_count = 0;  cycle_count = 0;  req_taken = 1'b0;
    send_idle_pct = 19;  recv_idle_pct = 77;
    for (int k = 0; k <= 256; k++) qs[k] = quarter_wave(k);
    for (int i = 0; i < 1024; i++) begin
      q = i & 511;
      sine_tab[i] = (q <= 256) ? qs[q] : qs[512 - q];
      if (i >= 512) sine_tab[i] = -sine_tab[i];
    end
    view_cfg = '{1'b0, 10'd0, 16'sd0, 16'sd0, 10'd300, 10'd300, 20'd10000, 10'd5};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed, at the reset settings: corners and the view centre.
    pixel_q = '{20'd0, {10'd1023, 10'd1023}, {10'd1023, 10'd0}, {10'd0, 10'd1023},
                {10'd300, 10'd300}, {10'd299, 10'd301}, {10'd512, 10'd511}};
    drain();

    // Perspective with the horizon at zero, so row 0 meets the zero-divisor
    // case, and the largest depth scale with negative extreme centres.
    view_cfg = '{1'b1, 10'd0, -16'sd32768, -16'sd32768, 10'd0, 10'd0, 20'hFFFFF, 10'd0};
    load_view();
    pixel_q = '{20'd0, {10'd0, 10'd1023}, {10'd0, 10'd200}, {10'd1, 10'd0},
                {10'd1023, 10'd1023}, {10'd1023, 10'd0}, {10'd5, 10'd100}};
    drain();

    // Top-down with out-of-range half sizes, largest angle and extreme pivot.
    view_cfg = '{1'b0, 10'd1023, 16'sd32767, -16'sd32768, 10'd1023, 10'd1023, 20'd0, 10'd1023};
    load_view();
    pixel_q = '{20'd0, {10'd1023, 10'd1023}, {10'd1023, 10'd0}, {10'd0, 10'd1023},
                {10'd512, 10'd512}};
    drain();

    // Random settings and pixels; the idling pattern changes part way.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 77;  recv_idle_pct = 19;
      end else if (ph == 6) begin
        send_idle_pct = 0;   recv_idle_pct = 0;
      end
      view_cfg.perspective_mode = ph[0];
      view_cfg.view_angle  = 10'($urandom_range(1023));
      view_cfg.centre_x    = 16'($urandom);
      view_cfg.centre_y    = 16'($urandom);
      view_cfg.half_width  = 10'($urandom_range(ph == 4 ? 1023 : 512));
      view_cfg.half_height = 10'($urandom_range(ph == 4 ? 1023 : 512));
      view_cfg.depth_scale = (ph == 7) ? 20'hFFFFF : 20'($urandom);
      view_cfg.horizon     = (ph == 5) ? 10'd1 : 10'($urandom_range(1, 1023));
      load_view();
      for (int n = 0; n < 45; n++) pixel_q.push_back(20'($urandom));
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
